/* src/ifla_pkg.sv */
// Package for the free-list index allocator.
// Request/result word types, request kinds, status codes and default pool depth.
// No dependencies.
package ifla_pkg;

  localparam int POOL_DEPTH = 1024;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;
  localparam int STAT_W  = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLAIM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_HEAD_BAD  = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_TAKEN     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOT_TAKEN = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] granted_index;
    logic [SIZE_W-1:0]  free_count;
  } rsp_t;

endpackage

/* src/ifla_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ifla_seq.sv */
// Sequencer and datapath of the free-list allocator: list rebuild sweep,
// allocate/claim/release steps and the list walk over the link RAM.
// Depends on ifla_pkg.
module ifla_seq #(
  parameter int POOL_DEPTH = ifla_pkg::POOL_DEPTH,
  localparam int IW = $clog2(POOL_DEPTH),
  localparam int PW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rebuild,
  input  logic [PW-1:0]       entries,
  input  logic                start,
  input  ifla_pkg::req_t      req,
  output logic                busy,
  output logic                cfg_ready,
  output logic                result_valid,
  output ifla_pkg::rsp_t      result,
  // link RAM: {taken, next}
  output logic                ram_we,
  output logic [IW-1:0]       ram_waddr,
  output logic [PW:0]         ram_wdata,
  output logic [IW-1:0]       ram_raddr,
  input  logic [PW:0]         ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_IDX   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;

  localparam logic [PW-1:0] LIST_END = PW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

  logic [2:0]                  state, state_next;
  logic [IW-1:0]               cnt, cnt_next;
  logic [PW-1:0]               head, head_next;
  logic [PW-1:0]               free_total, free_next;
  logic [ifla_pkg::KIND_W-1:0] kind, kind_next;
  logic [ifla_pkg::INDEX_W-1:0] idx, idx_next;
  logic [PW-1:0]               link_idx, link_idx_next;
  logic [PW-1:0]               cur, cur_next;
  logic [PW-1:0]               steps, steps_next;

  logic                        fin;
  logic [ifla_pkg::STAT_W-1:0] fin_status;
  logic [ifla_pkg::INDEX_W-1:0] fin_grant;

  logic                        rd_taken;
  logic [PW-1:0]               rd_link;
  logic [31:0]                 clr_next_idx;

  assign rd_taken     = ram_rdata[PW];
  assign rd_link      = ram_rdata[PW-1:0];
  assign clr_next_idx = 32'(cnt) + 32'd1;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = state inside {S_IDLE, S_CLEAR};

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    head_next     = head;
    free_next     = free_total;
    kind_next     = kind;
    idx_next      = idx;
    link_idx_next = link_idx;
    cur_next      = cur;
    steps_next    = steps;
    fin           = 1'b0;
    fin_status    = ifla_pkg::ST_OK;
    fin_grant     = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = {1'b0, (clr_next_idx < 32'(entries)) ? PW'(clr_next_idx) : LIST_END};
        head_next = '0;
        free_next = entries;
        cnt_next  = cnt + IW'(1);
        if (cnt == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_next = req.kind;
          idx_next  = req.index;
          if (req.kind == ifla_pkg::KIND_ALLOC) begin
            if (head == LIST_END) begin
              fin        = 1'b1;
              fin_status = ifla_pkg::ST_EMPTY;
            end else if (32'(head) >= 32'(entries) || free_total == '0) begin
              fin        = 1'b1;
              fin_status = ifla_pkg::ST_HEAD_BAD;
            end else begin
              ram_raddr  = IW'(head);
              state_next = S_ALLOC;
            end
          end else if (req.kind inside {ifla_pkg::KIND_CLAIM, ifla_pkg::KIND_RELEASE}) begin
            if (32'(req.index) >= 32'(entries)) begin
              fin        = 1'b1;
              fin_status = ifla_pkg::ST_RANGE;
            end else begin
              ram_raddr  = IW'(req.index);
              state_next = S_IDX;
            end
          end else begin
            fin        = 1'b1;
            fin_status = ifla_pkg::ST_RANGE;
          end
        end
      end

      S_ALLOC: begin
        // pop the head; keep its link, mark it taken
        ram_we     = 1'b1;
        ram_waddr  = IW'(head);
        ram_wdata  = {1'b1, rd_link};
        head_next  = rd_link;
        free_next  = free_total - PW'(1);
        fin        = 1'b1;
        fin_grant  = ifla_pkg::INDEX_W'(head);
        state_next = S_IDLE;
      end

      S_IDX: begin
        link_idx_next = rd_link;
        state_next    = S_IDLE;
        if (kind == ifla_pkg::KIND_RELEASE) begin
          if (!rd_taken) begin
            fin        = 1'b1;
            fin_status = ifla_pkg::ST_NOT_TAKEN;
          end else begin
            // push back on the head
            ram_we    = 1'b1;
            ram_waddr = IW'(idx);
            ram_wdata = {1'b0, head};
            head_next = PW'(idx);
            free_next = free_total + PW'(1);
            fin       = 1'b1;
          end
        end else if (rd_taken) begin
          fin        = 1'b1;
          fin_status = ifla_pkg::ST_TAKEN;
        end else if (32'(head) == 32'(idx)) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(idx);
          ram_wdata = {1'b1, rd_link};
          head_next = rd_link;
          if (free_total != '0) begin
            free_next = free_total - PW'(1);
          end
          fin       = 1'b1;
        end else if (32'(head) >= 32'(POOL_DEPTH)) begin
          fin        = 1'b1;
          fin_status = ifla_pkg::ST_NOT_FOUND;
        end else begin
          // walk from the head looking for the predecessor of idx
          cur_next   = head;
          steps_next = '0;
          ram_raddr  = IW'(head);
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        if (32'(rd_link) == 32'(idx)) begin
          ram_we     = 1'b1;
          ram_waddr  = IW'(cur);
          ram_wdata  = {1'b0, link_idx};
          state_next = S_MARK;
        end else if (32'(steps) >= 32'(POOL_DEPTH) ||
                     32'(rd_link) >= 32'(POOL_DEPTH)) begin
          fin        = 1'b1;
          fin_status = ifla_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          cur_next   = rd_link;
          steps_next = steps + PW'(1);
          ram_raddr  = IW'(rd_link);
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx);
        ram_wdata = {1'b1, link_idx};
        if (free_total != '0) begin
          free_next = free_total - PW'(1);
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (rebuild) begin
      state_next = S_CLEAR;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      head         <= '0;
      free_total   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      head         <= head_next;
      free_total   <= free_next;
      result_valid <= fin;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    idx      <= idx_next;
    link_idx <= link_idx_next;
    cur      <= cur_next;
    steps    <= steps_next;
    if (fin) begin
      result.status        <= fin_status;
      result.granted_index <= fin_grant;
      result.free_count    <= ifla_pkg::SIZE_W'(free_next);
    end
  end

endmodule

/* src/index_free_list_allocator.sv */
// Top level of the free-list index allocator: size register, link RAM and sequencer.
// Depends on ifla_pkg, ifla_ram and ifla_seq.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+-----------------------------------
//  request  | start, busy (in)          | req    : kind, index
//  result   | result_valid strobe (out) | result : status, granted_index,
//           |                           |          free_count
//  config   | cfg_valid, cfg_ready (in) | cfg_data : entries_in_use
//
// Steps: range, empty, bad-head and kind rejects end in the idle state; allocate
// pops the head in S_ALLOC; release and a claim that is taken, misses on an empty
// list or hits the head end in S_IDX; other claims walk the list in S_WALK and
// mark the index in S_MARK on a hit. One read port: the walk does one link per cycle.
// Reset and every size write run a rebuild sweep of the link RAM; busy stays high,
// size writes are still taken and restart it. No stalls: strobe lasts one cycle.
module index_free_list_allocator #(
  parameter int POOL_DEPTH = ifla_pkg::POOL_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ifla_pkg::req_t              req,
  output logic                        result_valid,
  output ifla_pkg::rsp_t              result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ifla_pkg::SIZE_W-1:0] cfg_data
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int PW = $clog2(POOL_DEPTH + 1);

  logic [PW-1:0] entries;
  logic [31:0]   cfg_wide;
  logic [PW-1:0] cfg_clamped;
  logic          cfg_write;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  logic [PW:0]   ram_wdata;
  logic [PW:0]   ram_rdata;

  // size clamp: zero reads as one, anything above the pool as the pool
  assign cfg_wide  = 32'(cfg_data);
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_wide == 32'd0) begin
      cfg_clamped = PW'(1);
    end else if (cfg_wide > 32'(POOL_DEPTH)) begin
      cfg_clamped = PW'(POOL_DEPTH);
    end else begin
      cfg_clamped = PW'(cfg_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= PW'(POOL_DEPTH);
    end else if (cfg_write) begin
      entries <= cfg_clamped;
    end
  end

  // link RAM word: {taken, next free index or end code}
  ifla_ram #(
    .WIDTH (PW + 1),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ifla_seq #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .rebuild      (cfg_write),
    .entries      (entries),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

endmodule

/* sim/ifla_free_list_mirror.sv */
// Checker for the free-list index allocator: keeps its own copy of the free list,
// predicts the result word of every accepted request and compares what comes out.
// Depends on ifla_pkg.
module ifla_free_list_mirror
  import ifla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  req_t              req,
  input  logic              result_valid,
  input  rsp_t              result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                mismatches,
  output int                outstanding
);

  localparam logic [SIZE_W-1:0] LINK_END = SIZE_W'(POOL_DEPTH);

  logic [SIZE_W-1:0] nxt_link [POOL_DEPTH];
  bit                in_use   [POOL_DEPTH];
  logic [SIZE_W-1:0] head_idx;
  logic [SIZE_W-1:0] free_cnt;
  logic [SIZE_W-1:0] pool_size;
  logic [SIZE_W-1:0] new_size;
  rsp_t              due_rsp [$];
  rsp_t              want;

  task automatic flag(input string what, input int got, input int exp_val);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // in-order list, everything free
  function automatic void rebuild_list();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      nxt_link[i] = (i + 1 < pool_size) ? SIZE_W'(i + 1) : LINK_END;
      in_use[i]   = 1'b0;
    end
    head_idx = '0;
    free_cnt = pool_size;
  endfunction

  function automatic rsp_t serve_request(input req_t w);
    rsp_t              r;
    logic [SIZE_W-1:0] idx;
    logic [SIZE_W-1:0] cur;
    int                steps;
    r   = '0;
    idx = SIZE_W'(w.index);
    case (w.kind)
      KIND_ALLOC: begin
        if (head_idx == LINK_END) begin
          r.status = ST_EMPTY;
        end else if (head_idx >= pool_size || free_cnt == 0) begin
          r.status = ST_HEAD_BAD;
        end else begin
          r.status                        = ST_OK;
          r.granted_index                 = head_idx[INDEX_W-1:0];
          free_cnt                        = free_cnt - SIZE_W'(1);
          in_use[head_idx[INDEX_W-1:0]]   = 1'b1;
          head_idx                        = nxt_link[head_idx[INDEX_W-1:0]];
        end
      end
      KIND_CLAIM: begin
        if (idx >= pool_size) begin
          r.status = ST_RANGE;
        end else if (in_use[w.index]) begin
          r.status = ST_TAKEN;
        end else begin
          r.status = ST_OK;
          if (head_idx == idx) begin
            head_idx = nxt_link[w.index];
          end else begin
            // find the predecessor; bounded walk
            cur   = head_idx;
            steps = 0;
            while (cur < LINK_END && nxt_link[cur[INDEX_W-1:0]] != idx &&
                   steps < POOL_DEPTH) begin
              cur = nxt_link[cur[INDEX_W-1:0]];
              steps++;
            end
            if (cur >= LINK_END || nxt_link[cur[INDEX_W-1:0]] != idx)
              r.status = ST_NOT_FOUND;
            else
              nxt_link[cur[INDEX_W-1:0]] = nxt_link[w.index];
          end
          if (r.status == ST_OK) begin
            if (free_cnt != 0) free_cnt = free_cnt - SIZE_W'(1);
            in_use[w.index] = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        if (idx >= pool_size) begin
          r.status = ST_RANGE;
        end else if (!in_use[w.index]) begin
          r.status = ST_NOT_TAKEN;
        end else begin
          r.status          = ST_OK;
          free_cnt          = free_cnt + SIZE_W'(1);
          nxt_link[w.index] = head_idx;
          head_idx          = idx;
          in_use[w.index]   = 1'b0;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.free_count = free_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pool_size = LINK_END;
      rebuild_list();
      due_rsp.delete();
    end else begin
      // a result word always belongs to a request taken earlier
      if (result_valid) begin
        if (due_rsp.size() == 0) begin
          flag("result word with none pending, status", result.status, 0);
        end else begin
          want = due_rsp.pop_front();
          if (result.status !== want.status)
            flag("status", result.status, want.status);
          if (result.granted_index !== want.granted_index)
            flag("granted_index", result.granted_index, want.granted_index);
          if (result.free_count !== want.free_count)
            flag("free_count", result.free_count, want.free_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        new_size = cfg_data;
        if (new_size == 0) new_size = SIZE_W'(1);
        else if (new_size > LINK_END) new_size = LINK_END;
        pool_size = new_size;
        rebuild_list();
      end
      if (start && !busy)
        due_rsp.push_back(serve_request(req));
    end
    outstanding <= due_rsp.size();
  end

endmodule

/* sim/index_free_list_allocator_tb.sv */
// Testbench top for the free-list index allocator: clock, reset, request and size
// stimulus, watchdog and verdict. Checking lives in ifla_free_list_mirror.
// Depends on ifla_pkg, index_free_list_allocator and ifla_free_list_mirror.
module index_free_list_allocator_tb;
  import ifla_pkg::*;

  // kind code the block has no operation for
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  // longest quiet stretch: rebuild sweep plus a full-length walk
  // plus the longest sender gap, taken several times over
  localparam int QUIET_LIMIT = 12000;
  localparam int RANDOM_WORDS = 1100;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              result_valid;
  rsp_t              result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int quiet;
  int cur_size;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  index_free_list_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  ifla_free_list_mirror mirror (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Watchdog: any accepted word (request, result or size write) restarts the count.
  always @(posedge clk) begin
    if (!rst && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t word_of(input logic [KIND_W-1:0] k,
                                   input logic [INDEX_W-1:0] i);
    req_t w;
    w.kind  = k;
    w.index = i;
    return w;
  endfunction

  // All drive tasks start and end at a falling edge. busy and cfg_ready only move
  // at rising edges, so reading them at the falling edge tells what the next
  // rising edge will see.
  task automatic send_word(input req_t w, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req   <= w;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start and hold off until every result word has come back.
  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Size write; only called with the block idle. The block clamps 0 up to 1 and
  // anything past POOL_DEPTH down to POOL_DEPTH, then sweeps the link RAM.
  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (v == 0) cur_size = 1;
    else if (v > POOL_DEPTH) cur_size = POOL_DEPTH;
    else cur_size = v;
  endtask

  // Mostly short gaps, a few long ones; bursts run back to back.
  function automatic int unsigned random_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (burst || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random request. Indexes are mostly in range so that allocs, claims and
  // releases interact with the live list; the rest sweep the whole field.
  // In a pool above 64 entries a claim may walk up to ~1000 links, so claims are rare there.
  function automatic req_t random_word();
    int unsigned       r;
    logic [KIND_W-1:0] k;
    logic [INDEX_W-1:0] i;
    r = $urandom_range(0, 99);
    if (r < 38)
      k = KIND_ALLOC;
    else if (r < 60)
      k = (cur_size > 64 && $urandom_range(0, 39) != 0) ? KIND_ALLOC : KIND_CLAIM;
    else if (r < 95)
      k = KIND_RELEASE;
    else
      k = KIND_UNKNOWN;
    if ($urandom_range(0, 4) == 0)
      i = INDEX_W'($urandom_range(0, 1023));
    else
      i = INDEX_W'($urandom_range(0, cur_size - 1));
    return word_of(k, i);
  endfunction

  initial begin
    int          sent;
    int          n;
    int unsigned r;
    bit          burst;
    logic [SIZE_W-1:0] size_word;

    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    cur_size  = POOL_DEPTH;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, full pool after reset ---
    send_word(word_of(KIND_ALLOC,   10'd0),    0);  // head 0
    send_word(word_of(KIND_ALLOC,   10'd0),    0);  // head 1
    send_word(word_of(KIND_CLAIM,   10'd1023), 0);  // deepest walk
    send_word(word_of(KIND_CLAIM,   10'd1023), 0);  // already taken
    send_word(word_of(KIND_RELEASE, 10'd1023), 0);
    send_word(word_of(KIND_RELEASE, 10'd1023), 0);  // not taken
    send_word(word_of(KIND_CLAIM,   10'd0),    0);  // taken by alloc
    send_word(word_of(KIND_RELEASE, 10'd0),    0);  // 0 back on head
    send_word(word_of(KIND_CLAIM,   10'd0),    0);  // claim hits head
    send_word(word_of(KIND_UNKNOWN, 10'd1023), 0);
    send_word(word_of(KIND_UNKNOWN, 10'd0),    0);
    send_word(word_of(KIND_RELEASE, 10'd512),  0);
    settle();

    // --- directed, size write of 0 -> single-entry pool ---
    write_size(11'd0);
    send_word(word_of(KIND_ALLOC,   10'd0),    0);
    send_word(word_of(KIND_ALLOC,   10'd0),    0);  // list empty
    send_word(word_of(KIND_CLAIM,   10'd0),    0);  // taken
    send_word(word_of(KIND_CLAIM,   10'd1),    0);  // out of range
    send_word(word_of(KIND_RELEASE, 10'd1023), 0);  // out of range
    send_word(word_of(KIND_RELEASE, 10'd0),    0);
    send_word(word_of(KIND_CLAIM,   10'd0),    0);
    send_word(word_of(KIND_RELEASE, 10'd0),    0);
    settle();

    // all-ones size write clamps to POOL_DEPTH
    write_size(11'h7FF);
    send_word(word_of(KIND_ALLOC,   10'd0),    0);
    send_word(word_of(KIND_RELEASE, 10'd0),    0);
    settle();

    // --- random phases: new size each phase, the sender drains before the write ---
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 11);
      case (r)
        0:       size_word = 11'd0;
        1:       size_word = 11'd1;
        2:       size_word = SIZE_W'(POOL_DEPTH);
        3:       size_word = SIZE_W'($urandom_range(POOL_DEPTH + 1, 2047));
        default: size_word = SIZE_W'($urandom_range(2, 48));
      endcase
      write_size(size_word);
      n     = $urandom_range(20, 80);
      burst = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < n; j++)
        send_word(random_word(), random_gap(burst));
      sent += n;
      settle();
    end

    // trailing cycles catch any stray result word
    repeat (16) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* index_free_list_allocator.f */
src/ifla_pkg.sv
src/ifla_ram.sv
src/ifla_seq.sv
src/index_free_list_allocator.sv
sim/ifla_free_list_mirror.sv
sim/index_free_list_allocator_tb.sv
